// ----- design/cqf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the circular queue FIFO.
// Used by cqf_cell, circular_queue_fifo and cqf_checker; no dependencies.
package cqf_pkg;

    localparam int DataW   = 32;
    localparam int OpW     = 2;
    localparam int StatusW = 2;
    localparam int CountW  = 4;
    localparam int OutDataW = 72;

    localparam logic [OpW-1:0] OP_ENQ = 2'd0;
    localparam logic [OpW-1:0] OP_DEQ = 2'd1;
    localparam logic [OpW-1:0] OP_CLR = 2'd2;
    localparam logic [OpW-1:0] OP_NOP = 2'd3;

    localparam logic [StatusW-1:0] ST_OK    = 2'd0;
    localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
    localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;

    localparam logic [CountW-1:0] COUNT_MAX = 4'd15;

    // Per-beat command broadcast to every cell of the chain
    typedef struct packed {
        logic load;   // successful enqueue
        logic shift;  // successful dequeue
        logic clear;  // drop all entries
    } cell_ctrl_t;

endpackage

// ----- design/circular_queue_fifo.sv -----
`timescale 1ns / 1ps
// Top level of the circular queue FIFO: a chain of DEPTH-1 cells with the head
// in cell 0, a fill counter and a registered result stage. Uses cqf_pkg, cqf_cell.
//
//  channel   dir  tuser           tdata
//  s_axis    in   opcode[1:0]     push_value[31:0]
//  m_axis    out  status[1:0]     popped, count, empty, head_value, head_valid
//
// One beat per cycle while the output is not stalled: the cells shift or load
// at the end of the accept cycle, and the result is written into the output register then.
// Reset clears the occupied flags, the counter and the output valid flag.
// A stalled output holds its beat; the input takes a new beat whenever the
// output register is empty or is being drained in the same cycle.
module circular_queue_fifo
#(
    parameter int DEPTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,  // push_value[31:0]
    input  logic [7:0]                   s_axis_tuser,  // opcode[1:0], zeros above
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // popped_value[31:0], entry_count[35:32], is_empty[36], head_value[68:37],
    // head_valid[69], zeros [71:70]
    output logic [cqf_pkg::OutDataW-1:0] m_axis_tdata,
    output logic [7:0]                   m_axis_tuser   // status[1:0], zeros above
);

    localparam int NC = DEPTH - 1;
    localparam int CW = $clog2(DEPTH);

    logic                      vld [0:NC];
    logic [cqf_pkg::DataW-1:0] dat [0:NC];

    cqf_pkg::cell_ctrl_t        ctrl;
    logic                       accept;
    logic [cqf_pkg::OpW-1:0]    op;
    logic                       is_full;
    logic                       was_empty;
    logic [cqf_pkg::StatusW-1:0] status;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic                        out_valid_reg;
    logic [cqf_pkg::OutDataW-1:0] out_data_reg;
    logic [cqf_pkg::OutDataW-1:0] out_data_next;
    logic [7:0]                  out_user_reg;
    logic [7:0]                  out_user_next;

    logic [cqf_pkg::DataW-1:0]  popped;
    logic [cqf_pkg::DataW-1:0]  head_raw;
    logic [cqf_pkg::DataW-1:0]  head_val;
    logic                       empty_after;
    logic [cqf_pkg::CountW-1:0] count_out;

    // sentinel past the last cell
    assign vld[NC] = 1'b0;
    assign dat[NC] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < NC; gi++)
        begin : g_cell
            logic prev_v;
            if (gi == 0)
            begin : g_first
                assign prev_v = 1'b1;
            end
            else
            begin : g_rest
                assign prev_v = vld[gi-1];
            end

            cqf_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .push_value (s_axis_tdata),
                .prev_valid (prev_v),
                .next_valid (vld[gi+1]),
                .next_data  (dat[gi+1]),
                .valid      (vld[gi]),
                .data       (dat[gi])
            );
        end
    endgenerate

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = s_axis_tuser[cqf_pkg::OpW-1:0];
    assign was_empty     = !vld[0];
    assign is_full       = vld[NC-1];

    always_comb
    begin
        ctrl       = '0;
        status     = cqf_pkg::ST_OK;
        count_next = count_reg;
        popped     = '0;
        head_raw   = dat[0];
        unique case (op)
            cqf_pkg::OP_ENQ:
            begin
                if (is_full)
                begin
                    status = cqf_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.load  = accept;
                    count_next = count_reg + 1'b1;
                    if (was_empty)
                    begin
                        head_raw = s_axis_tdata;
                    end
                end
            end
            cqf_pkg::OP_DEQ:
            begin
                if (was_empty)
                begin
                    status = cqf_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.shift = accept;
                    count_next = count_reg - 1'b1;
                    popped     = dat[0];
                    head_raw   = dat[1];
                end
            end
            cqf_pkg::OP_CLR:
            begin
                ctrl.clear = accept;
                count_next = '0;
            end
            default:
            begin
                // status query: nothing moves
            end
        endcase
    end

    always_comb
    begin
        empty_after = (count_next == '0);
        head_val    = empty_after ? '0 : head_raw;
        if (32'(count_next) > 32'(cqf_pkg::COUNT_MAX))
        begin
            count_out = cqf_pkg::COUNT_MAX;
        end
        else
        begin
            count_out = cqf_pkg::CountW'(count_next);
        end
        out_data_next = {2'b00, !empty_after, head_val, empty_after, count_out, popped};
        out_user_next = {6'd0, status};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// ----- design/cqf_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of the queue chain: holds one word and its occupied flag.
// Depends on cqf_pkg for cell_ctrl_t and the data width.
module cqf_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cqf_pkg::cell_ctrl_t       ctrl,
    input  logic [cqf_pkg::DataW-1:0] push_value,
    input  logic                      prev_valid,
    input  logic                      next_valid,
    input  logic [cqf_pkg::DataW-1:0] next_data,
    output logic                      valid,
    output logic [cqf_pkg::DataW-1:0] data
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [cqf_pkg::DataW-1:0] data_reg;
    logic [cqf_pkg::DataW-1:0] data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            // advance toward the head
            valid_next = next_valid;
            data_next  = next_data;
        end
        else if (ctrl.load && !valid_reg && prev_valid)
        begin
            // first free cell takes the new tail word
            valid_next = 1'b1;
            data_next  = push_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ----- design/cqf_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for circular_queue_fifo, attached by the bind at the end.
// Depends on cqf_pkg for the status codes and the output width.
module cqf_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [31:0]                  s_axis_tdata,
    input logic [7:0]                   s_axis_tuser,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [cqf_pkg::OutDataW-1:0] m_axis_tdata,
    input logic [7:0]                   m_axis_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // empty flag, zero count and missing head agree
    a_empty_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[36] == (m_axis_tdata[35:32] == 4'd0))
                          && (m_axis_tdata[36] == !m_axis_tdata[69]))
        else $error("empty flag disagrees with count or head_valid");

    // a refused dequeue leaves an empty queue
    a_deq_refused: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] == cqf_pkg::ST_EMPTY) |-> m_axis_tdata[36])
        else $error("dequeue refused on a non-empty queue");

    // an accepted clear reports an empty queue on the next beat
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == cqf_pkg::OP_CLR)
        |=> m_axis_tvalid && m_axis_tdata[36] && (m_axis_tuser[1:0] == cqf_pkg::ST_OK))
        else $error("clear did not empty the queue");

endmodule

bind circular_queue_fifo cqf_checker u_cqf_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- test/cqf_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the circular queue FIFO: watches both stream channels, predicts
// every result beat with a ring-buffer model of its own and compares field by field.
// Depends on cqf_pkg.
module cqf_scoreboard
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,   // push_value[31:0]
    input  logic [7:0]                   s_axis_tuser,   // opcode[1:0], zeros above
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // popped_value[31:0], entry_count[35:32], is_empty[36], head_value[68:37],
    // head_valid[69], zeros [71:70]
    input  logic [cqf_pkg::OutDataW-1:0] m_axis_tdata,
    input  logic [7:0]                   m_axis_tuser,   // status[1:0], zeros above
    output int                           mismatch_count,
    output int                           pending_results,
    output int                           results_checked,
    output int                           full_refusals,
    output int                           empty_refusals
);

    // Ring of 16 slots, matching the DEPTH the testbench gives the block
    localparam int IdxW      = 4;
    localparam int RingSlots = 16;

    typedef struct packed {
        logic [cqf_pkg::StatusW-1:0] status;
        logic [cqf_pkg::DataW-1:0]   popped;
        logic [cqf_pkg::CountW-1:0]  count;
        logic                        empty;
        logic [cqf_pkg::DataW-1:0]   head;
        logic                        head_ok;
    } queue_result_t;

    logic [cqf_pkg::DataW-1:0] ring_slots [RingSlots];
    logic [IdxW-1:0]           ring_head;
    logic [IdxW-1:0]           ring_tail;

    queue_result_t awaited_results [$];
    queue_result_t want;
    queue_result_t got;
    int            fails;
    int            checked;
    int            full_seen;
    int            empty_seen;

    function automatic queue_result_t predict_step(input logic [cqf_pkg::OpW-1:0] op,
                                                   input logic [cqf_pkg::DataW-1:0] val);
        queue_result_t   r;
        logic [IdxW-1:0] tail_next;
        r         = '0;
        r.status  = cqf_pkg::ST_OK;
        tail_next = ring_tail + 1'b1;
        case (op)
            cqf_pkg::OP_ENQ:
            begin
                // one slot stays free, so tail+1 hitting head means full
                if (tail_next == ring_head)
                    r.status = cqf_pkg::ST_FULL;
                else
                begin
                    ring_slots[ring_tail] = val;
                    ring_tail             = tail_next;
                end
            end
            cqf_pkg::OP_DEQ:
            begin
                if (ring_head == ring_tail)
                    r.status = cqf_pkg::ST_EMPTY;
                else
                begin
                    r.popped  = ring_slots[ring_head];
                    ring_head = ring_head + 1'b1;
                end
            end
            cqf_pkg::OP_CLR:
            begin
                // slot contents stay, they are just out of reach
                ring_head = '0;
                ring_tail = '0;
            end
            default: ;
        endcase
        r.count   = ring_tail - ring_head;
        r.empty   = (ring_head == ring_tail);
        r.head_ok = !r.empty;
        r.head    = r.empty ? '0 : ring_slots[ring_head];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] checker: %s", $time, msg);
        fails++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] seen,
                                 input logic [31:0] awaited);
        if (seen !== awaited)
            report_mismatch($sformatf("result %0d, %s: got %h, expected %h",
                                      checked, name, seen, awaited));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_results.delete();
            ring_head       = '0;
            ring_tail       = '0;
            fails           = 0;
            checked         = 0;
            full_seen       = 0;
            empty_seen      = 0;
            mismatch_count  <= 0;
            pending_results <= 0;
            results_checked <= 0;
            full_refusals   <= 0;
            empty_refusals  <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = predict_step(s_axis_tuser[cqf_pkg::OpW-1:0], s_axis_tdata);
                if (want.status == cqf_pkg::ST_FULL)
                    full_seen++;
                if (want.status == cqf_pkg::ST_EMPTY)
                    empty_seen++;
                awaited_results.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status  = m_axis_tuser[cqf_pkg::StatusW-1:0];
                got.popped  = m_axis_tdata[31:0];
                got.count   = m_axis_tdata[35:32];
                got.empty   = m_axis_tdata[36];
                got.head    = m_axis_tdata[68:37];
                got.head_ok = m_axis_tdata[69];
                if (awaited_results.size() == 0)
                    report_mismatch($sformatf("result beat with nothing expected, tdata %h",
                                              m_axis_tdata));
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("status", 32'(got.status), 32'(want.status));
                    compare_field("popped_value", got.popped, want.popped);
                    compare_field("entry_count", 32'(got.count), 32'(want.count));
                    compare_field("is_empty", 32'(got.empty), 32'(want.empty));
                    compare_field("head_value", got.head, want.head);
                    compare_field("head_valid", 32'(got.head_ok), 32'(want.head_ok));
                end
                checked++;
            end
            mismatch_count  <= fails;
            pending_results <= awaited_results.size();
            results_checked <= checked;
            full_refusals   <= full_seen;
            empty_refusals  <= empty_seen;
        end
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Top of the circular queue FIFO testbench: clock, reset, command stimulus and
// result-side back-pressure. Depends on cqf_pkg, circular_queue_fifo and cqf_scoreboard.
module testbench;

    localparam int RandomOps = 1650;

    logic                         clk           = 1'b0;
    logic                         rst_n         = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic [31:0]                  s_axis_tdata  = '0;
    logic [7:0]                   s_axis_tuser  = '0;
    logic                         m_axis_tready = 1'b0;
    logic                         s_axis_tready;
    logic                         m_axis_tvalid;
    logic [cqf_pkg::OutDataW-1:0] m_axis_tdata;
    logic [7:0]                   m_axis_tuser;

    int mismatch_count;
    int pending_results;
    int results_checked;
    int full_refusals;
    int empty_refusals;
    int beats_sent = 0;
    bit burst_mode = 1'b0;

    circular_queue_fifo #(.DEPTH(16)) u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    cqf_scoreboard u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .full_refusals   (full_refusals),
        .empty_refusals  (empty_refusals)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Offer one command beat, hold it until accepted, then drop valid for the gap from pick_gap if it is nonzero
    task automatic send_beat(input logic [cqf_pkg::OpW-1:0] op,
                             input logic [cqf_pkg::DataW-1:0] val);
        int gap;
        gap = pick_gap();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {{(8-cqf_pkg::OpW){1'b0}}, op};
        s_axis_tdata  <= val;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        beats_sent++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                        r;
        bit                        fill_phase;
        logic [cqf_pkg::OpW-1:0]   op;
        logic [cqf_pkg::DataW-1:0] val;
        fill_phase = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue: status query, refused dequeue
        send_beat(cqf_pkg::OP_NOP, 32'h0000_0000);
        send_beat(cqf_pkg::OP_DEQ, 32'hFFFF_FFFF);
        // fill to DEPTH-1 entries, extremes first
        send_beat(cqf_pkg::OP_ENQ, 32'h8000_0000);
        send_beat(cqf_pkg::OP_ENQ, 32'h7FFF_FFFF);
        send_beat(cqf_pkg::OP_ENQ, 32'h0000_0000);
        send_beat(cqf_pkg::OP_ENQ, 32'hFFFF_FFFF);
        for (int i = 0; i < 11; i++)
            send_beat(cqf_pkg::OP_ENQ, $urandom);
        // full queue: refused enqueue, then status query
        send_beat(cqf_pkg::OP_ENQ, 32'h5555_AAAA);
        send_beat(cqf_pkg::OP_NOP, 32'hAAAA_5555);
        for (int i = 0; i < 3; i++)
            send_beat(cqf_pkg::OP_DEQ, $urandom);
        send_beat(cqf_pkg::OP_CLR, $urandom);
        send_beat(cqf_pkg::OP_DEQ, $urandom);
        send_beat(cqf_pkg::OP_ENQ, 32'h1234_5678);

        for (int i = 0; i < RandomOps; i++)
        begin
            if (i % 60 == 0)
                fill_phase = 1'($urandom_range(0, 1));
            if (i % 150 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            if (i == 800)
                hold_until_drained();
            // fill phases push the queue to full, drain phases down to empty
            r = $urandom_range(0, 99);
            if (r < (fill_phase ? 62 : 25))
                op = cqf_pkg::OP_ENQ;
            else if (r < 88)
                op = cqf_pkg::OP_DEQ;
            else if (r < 89)
                op = cqf_pkg::OP_CLR;
            else
                op = cqf_pkg::OP_NOP;
            case ($urandom_range(0, 19))
                0:       val = 32'h8000_0000;
                1:       val = 32'h7FFF_FFFF;
                2:       val = 32'h0000_0000;
                3:       val = 32'hFFFF_FFFF;
                default: val = $urandom;
            endcase
            send_beat(op, val);
        end

        hold_until_drained();
        repeat (8) @(posedge clk);
        $display("Covered %0d commands and %0d result beats, including %0d refused enqueues",
                 beats_sent, results_checked, full_refusals);
        $display("on a full queue and %0d refused dequeues on an empty one.", empty_refusals);
        if (mismatch_count == 0)
            $display("** circular_queue_fifo: PASSED **");
        else
            $display("** circular_queue_fifo: FAILED **");
        $finish;
    end

    initial
    begin : sink
        int r;
        int span;
        bit long_hold_done;
        long_hold_done = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (!long_hold_done && beats_sent >= 400)
            begin
                // long hold-off: output register fills and the input stalls
                long_hold_done = 1'b1;
                m_axis_tready  <= 1'b0;
                span           = 150;
            end
            else if (r < 70)
            begin
                m_axis_tready <= 1'b1;
                span          = $urandom_range(1, 8);
            end
            else if (r < 90)
            begin
                m_axis_tready <= 1'b0;
                span          = $urandom_range(1, 3);
            end
            else if (r < 96)
            begin
                m_axis_tready <= 1'b0;
                span          = $urandom_range(8, 30);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                span          = $urandom_range(40, 100);
            end
            repeat (span) @(posedge clk);
        end
    end

    // Generous bound: far beyond the slowest legal run of this stimulus
    initial
    begin : watchdog
        #10_000_000;
        $display("** circular_queue_fifo: FAILED **");
        $finish;
    end

endmodule
